/* design/uart_baud_divisor_calc_unit_defines.svh */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: assertion macros
// Shared property shorthands for the checker; all sample on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_UNIT_DEFINES_SVH
`define UART_BAUD_DIVISOR_CALC_UNIT_DEFINES_SVH

// same-cycle implication
`define UBDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ubdc_pkg.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: package
// Widths, constants, stage control struct and the fraction rounding function.
// ----------------------------------------------------------------------------
package ubdc_pkg;

  localparam int CLOCK_BITS_DEF = 28;
  localparam int BAUD_BITS_DEF  = 24;

  localparam int CLK_SCALE   = 25;    // divisor x100 = 25*clk/(4 or 2 * baud)
  localparam int DIV_BASE    = 100;
  localparam int R100_W      = 7;     // remainder by 100
  localparam int FRAC_ROUND  = 50;
  localparam int RECIP_100   = 5243;  // 2^19/100, exact for x < 1700
  localparam int RECIP_SHIFT = 19;
  localparam int MANT_W      = 12;
  localparam int FRAC_W      = 4;
  localparam int WORD_W      = 16;

  localparam logic [3:0]        FRAC16_MASK = 4'h0F;
  localparam logic [2:0]        FRAC8_MASK  = 3'h07;
  localparam logic [WORD_W-1:0] WORD_SAT    = 16'hFFFF;

  typedef struct packed {
    logic valid;
    logic ovs8;
    logic baud_zero;
  } ubdc_ctl_t;

  // round remainder (0..99) to 4 or 3 fraction bits, carry masked away
  function automatic logic [FRAC_W-1:0] ubdc_frac(input logic [R100_W-1:0] rem,
                                                  input logic ovs8);
    logic [10:0] x;
    logic [23:0] p;
    logic [4:0]  q;
    x = ovs8 ? {1'b0, rem, 3'b000} : {rem, 4'b0000};
    x = x + 11'(FRAC_ROUND);
    p = 24'(x) * 24'(RECIP_100);
    q = p[RECIP_SHIFT +: 5];
    return ovs8 ? {1'b0, q[2:0] & FRAC8_MASK} : (q[3:0] & FRAC16_MASK);
  endfunction

endpackage

/* design/ubdc_if.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: channel interfaces
// Request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ubdc_in_if #(
  parameter int CLOCK_BITS = ubdc_pkg::CLOCK_BITS_DEF,
  parameter int BAUD_BITS  = ubdc_pkg::BAUD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [CLOCK_BITS-1:0] bus_clock_hz;
  logic [BAUD_BITS-1:0]  baud_rate;

  modport source (output valid, output bus_clock_hz, output baud_rate, input ready);
  modport sink   (input valid, input bus_clock_hz, input baud_rate, output ready);
endinterface

interface ubdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] divisor_word;
  logic        mantissa_overflow;

  modport source (output valid, output divisor_word, output mantissa_overflow,
                  input ready);
  modport sink   (input valid, input divisor_word, input mantissa_overflow,
                  output ready);
endinterface

interface ubdc_cfg_if;
  logic valid;
  logic ready;
  logic oversample_by_8;

  modport source (output valid, output oversample_by_8, input ready);
  modport sink   (input valid, input oversample_by_8, output ready);
endinterface

/* design/ubdc_prep.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: operand stage
// Forms 25*clock and the 4x or 2x scaled baud divisor for the divider.
// ----------------------------------------------------------------------------
module ubdc_prep #(
  parameter int CLOCK_BITS = ubdc_pkg::CLOCK_BITS_DEF,
  parameter int BAUD_BITS  = ubdc_pkg::BAUD_BITS_DEF,
  parameter int NW         = CLOCK_BITS + 5,
  parameter int DW         = BAUD_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [CLOCK_BITS-1:0] clk_hz,
  input  logic [BAUD_BITS-1:0]  baud,
  input  logic                  ovs8,
  output ubdc_pkg::ubdc_ctl_t   ctl_o,
  output logic [NW-1:0]         acc_o,
  output logic [DW-1:0]         den_o
);
  import ubdc_pkg::*;

  ubdc_ctl_t     ctl_r, ctl_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] den_r, den_nxt;

  always_comb begin
    ctl_nxt.valid     = in_valid;
    ctl_nxt.ovs8      = ovs8;
    ctl_nxt.baud_zero = (baud == '0);
    acc_nxt = NW'(clk_hz) * NW'(CLK_SCALE);
    den_nxt = ovs8 ? {1'b0, baud, 1'b0} : {baud, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      den_r <= den_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign den_o = den_r;

endmodule

/* design/ubdc_div_stage.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: divider stage
// One restoring step of scaled = N/D, and the quotient bit it yields fed
// straight into one step of scaled/100. acc holds the unused numerator bits
// on top and the built-up mantissa bits below.
// ----------------------------------------------------------------------------
module ubdc_div_stage #(
  parameter int NW = ubdc_pkg::CLOCK_BITS_DEF + 5,
  parameter int DW = ubdc_pkg::BAUD_BITS_DEF + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  ubdc_pkg::ubdc_ctl_t         ctl_i,
  input  logic [NW-1:0]               acc_i,
  input  logic [DW-1:0]               den_i,
  input  logic [DW-1:0]               rem_i,
  input  logic [ubdc_pkg::R100_W-1:0] r100_i,
  output ubdc_pkg::ubdc_ctl_t         ctl_o,
  output logic [NW-1:0]               acc_o,
  output logic [DW-1:0]               den_o,
  output logic [DW-1:0]               rem_o,
  output logic [ubdc_pkg::R100_W-1:0] r100_o
);
  import ubdc_pkg::*;

  ubdc_ctl_t         ctl_r;
  logic [NW-1:0]     acc_r, acc_nxt;
  logic [DW-1:0]     den_r;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [R100_W-1:0] r100_r, r100_nxt;
  logic [DW:0]       part;
  logic [DW:0]       diff;
  logic              qbit;
  logic [R100_W:0]   part2;
  logic              mbit;

  always_comb begin
    part    = {rem_i, acc_i[NW-1]};
    diff    = part - {1'b0, den_i};
    qbit    = (part >= {1'b0, den_i});
    rem_nxt = qbit ? diff[DW-1:0] : part[DW-1:0];
    // remainder by 100 stays below 100, so part2 < 200
    part2    = {r100_i, qbit};
    mbit     = (part2 >= (R100_W+1)'(DIV_BASE));
    r100_nxt = mbit ? R100_W'(part2 - (R100_W+1)'(DIV_BASE)) : part2[R100_W-1:0];
    acc_nxt  = {acc_i[NW-2:0], mbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= acc_nxt;
      den_r  <= den_i;
      rem_r  <= rem_nxt;
      r100_r <= r100_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign acc_o  = acc_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign r100_o = r100_r;

endmodule

/* design/ubdc_finish.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: result stage
// Rounds the fraction, packs the word, and holds results in an output
// register backed by a skid register so the pipeline can run ahead.
// ----------------------------------------------------------------------------
module ubdc_finish #(
  parameter int NW = ubdc_pkg::CLOCK_BITS_DEF + 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ubdc_pkg::ubdc_ctl_t         ctl_i,
  input  logic [NW-1:0]               mant_i,
  input  logic [ubdc_pkg::R100_W-1:0] r100_i,
  output logic                        adv_o,
  ubdc_out_if.source                  out_ch
);
  import ubdc_pkg::*;

  logic [WORD_W-1:0] res_word;
  logic              res_ovf;
  logic              exit_v;
  logic              take;
  logic              out_load;
  logic              skid_load;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [WORD_W-1:0] out_word_r, skid_word_r;
  logic              out_ovf_r, skid_ovf_r;

  always_comb begin
    if (ctl_i.baud_zero) begin
      res_word = WORD_SAT;
      res_ovf  = 1'b1;
    end else begin
      res_word = {mant_i[MANT_W-1:0], ubdc_frac(r100_i, ctl_i.ovs8)};
      res_ovf  = |mant_i[NW-1:MANT_W];
    end
  end

  assign adv_o  = !skid_valid_r;
  assign exit_v = adv_o && ctl_i.valid;
  assign take   = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    skid_load      = 1'b0;
    if (!out_valid_r || take) begin
      out_valid_nxt  = skid_valid_r || exit_v;
      out_load       = 1'b1;
      skid_valid_nxt = 1'b0;
    end else if (exit_v) begin
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= skid_valid_r ? skid_word_r : res_word;
      out_ovf_r  <= skid_valid_r ? skid_ovf_r : res_ovf;
    end
    if (skid_load) begin
      skid_word_r <= res_word;
      skid_ovf_r  <= res_ovf;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.divisor_word      = out_word_r;
  assign out_ch.mantissa_overflow = out_ovf_r;

endmodule

/* design/uart_baud_divisor_calc_unit.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: top level
// Takes one item per cycle while the skid register is empty; each item passes
// through one operand stage, one divider stage per bit of 25*clock (a
// restoring step against the scaled baud rate, chained with a step of the
// division by 100), and an output register. A skid register behind the output
// lets the pipe keep moving for one item while the result side stalls. A zero
// baud rate gives 0xFFFF with the overflow flag. The oversampling mode is
// sampled per item.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_unit #(
  parameter int CLOCK_BITS = ubdc_pkg::CLOCK_BITS_DEF,
  parameter int BAUD_BITS  = ubdc_pkg::BAUD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ubdc_in_if.sink    in_ch,
  ubdc_out_if.source out_ch,
  ubdc_cfg_if.sink   cfg_ch
);
  import ubdc_pkg::*;

  localparam int NW = CLOCK_BITS + 5;
  localparam int DW = BAUD_BITS + 2;

  logic              ovs8_r;
  logic              adv;
  ubdc_ctl_t         ctl_s  [0:NW];
  logic [NW-1:0]     acc_s  [0:NW];
  logic [DW-1:0]     den_s  [0:NW-1];
  logic [DW-1:0]     rem_s  [0:NW-1];
  logic [R100_W-1:0] r100_s [0:NW];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovs8_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      ovs8_r <= cfg_ch.oversample_by_8;
    end
  end

  assign in_ch.ready = adv;

  ubdc_prep #(
    .CLOCK_BITS (CLOCK_BITS),
    .BAUD_BITS  (BAUD_BITS),
    .NW         (NW),
    .DW         (DW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .clk_hz   (in_ch.bus_clock_hz),
    .baud     (in_ch.baud_rate),
    .ovs8     (ovs8_r),
    .ctl_o    (ctl_s[0]),
    .acc_o    (acc_s[0]),
    .den_o    (den_s[0])
  );

  assign rem_s[0]  = '0;
  assign r100_s[0] = '0;

  for (genvar k = 0; k < NW; k++) begin : g_div
    if (k == NW - 1) begin : g_last
      ubdc_div_stage #(.NW(NW), .DW(DW)) u_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .ctl_i  (ctl_s[k]),
        .acc_i  (acc_s[k]),
        .den_i  (den_s[k]),
        .rem_i  (rem_s[k]),
        .r100_i (r100_s[k]),
        .ctl_o  (ctl_s[k+1]),
        .acc_o  (acc_s[k+1]),
        .den_o  (),
        .rem_o  (),
        .r100_o (r100_s[k+1])
      );
    end else begin : g_mid
      ubdc_div_stage #(.NW(NW), .DW(DW)) u_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .ctl_i  (ctl_s[k]),
        .acc_i  (acc_s[k]),
        .den_i  (den_s[k]),
        .rem_i  (rem_s[k]),
        .r100_i (r100_s[k]),
        .ctl_o  (ctl_s[k+1]),
        .acc_o  (acc_s[k+1]),
        .den_o  (den_s[k+1]),
        .rem_o  (rem_s[k+1]),
        .r100_o (r100_s[k+1])
      );
    end
  end

  ubdc_finish #(.NW(NW)) u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_s[NW]),
    .mant_i (acc_s[NW]),
    .r100_i (r100_s[NW]),
    .adv_o  (adv),
    .out_ch (out_ch)
  );

endmodule

/* design/ubdc_checker.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: port checker
// Watches the top-level handshakes; bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "uart_baud_divisor_calc_unit_defines.svh"

module ubdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] divisor_word,
  input logic        mantissa_overflow
);

  // a held result keeps its value
  `UBDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(divisor_word) && $stable(mantissa_overflow), "result changed while stalled")

  // with no result pending the skid is empty, so requests are taken
  `UBDC_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty output")

  // input backpressure only follows a stalled output item
  `UBDC_ASSERT_IMP(a_ready_fall, $fell(in_ready), $past(out_valid && !out_ready), "input blocked without output stall")

  // an accepted item never makes the input side drop ready at once on its own
  `UBDC_ASSERT_NEXT(a_accept_free, in_valid && in_ready && out_ready, in_ready, "input blocked while output drains")

endmodule

bind uart_baud_divisor_calc_unit ubdc_checker u_ubdc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .divisor_word      (out_ch.divisor_word),
  .mantissa_overflow (out_ch.mantissa_overflow)
);
